// ----- rtl/dms_pkg.sv -----
// Descent mission sequencer: shared item types, register map and phase codes.
// No dependencies; every other file in rtl/ imports this package.
package dms_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATION_ALT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOVER_ALT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_ALT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUND_ALT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EMERG_ALT_MIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EMERG_SPEED    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_EMERG_CONFIRM  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HOVER_TIME     = 3'd7;

    // Command codes (code three is unused and ignored)
    localparam logic [1:0] CMD_UPDATE = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_STOP   = 2'd2;

    // Velocity-control modes
    localparam logic [1:0] VM_NONE   = 2'd0;
    localparam logic [1:0] VM_ACTIVE = 2'd1;
    localparam logic [1:0] VM_HOVER  = 2'd2;
    localparam logic [1:0] VM_SOFT   = 2'd3;

    // Mission phases
    typedef enum logic [2:0] {
        PH_FALL     = 3'd0,
        PH_SEPARATE = 3'd1,
        PH_POWERED  = 3'd2,
        PH_HOVER    = 3'd3,
        PH_DESCENT  = 3'd4,
        PH_LANDING  = 3'd5,
        PH_DONE     = 3'd6,
        PH_EMERG    = 3'd7
    } t_phase;

    // Input item
    typedef struct packed {
        logic [1:0]         cmd;
        logic [31:0]        now_ms;
        logic               sensor_ok;
        logic signed [23:0] altitude_cm;
        logic signed [15:0] vspeed_cms;
        logic               sep_confirmed;
        logic               touchdown;
        logic               emergency_request;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [2:0]  phase;
        logic        sep_fire;
        logic        parachute_cmd;
        logic        motors_armed;
        logic [1:0]  velocity_mode;
        logic [31:0] phase_time_ms;
    } t_out_item;

    // Configuration register contents
    typedef struct packed {
        logic [22:0]        separation_alt_cm;
        logic [22:0]        hover_alt_cm;
        logic [22:0]        slow_alt_cm;
        logic signed [23:0] ground_alt_cm;
        logic [22:0]        emerg_alt_min_cm;
        logic [14:0]        emerg_speed_cms;
        logic [15:0]        emerg_confirm_ms;
        logic [15:0]        hover_dwell_ms;
    } t_cfg;

endpackage

// ----- rtl/dms_cfg_regs.sv -----
// Descent mission sequencer: configuration register file (write-only).
// Depends on dms_pkg for the register map and the t_cfg struct.
module dms_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dms_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dms_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output dms_pkg::t_cfg                  o_cfg
);
    import dms_pkg::*;

    t_cfg r_cfg;

    // Register writes, each truncated to its own width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.separation_alt_cm <= 23'd100000;
            r_cfg.hover_alt_cm      <= 23'd20000;
            r_cfg.slow_alt_cm       <= 23'd5000;
            r_cfg.ground_alt_cm     <= 24'sd0;
            r_cfg.emerg_alt_min_cm  <= 23'd10000;
            r_cfg.emerg_speed_cms   <= 15'd2000;
            r_cfg.emerg_confirm_ms  <= 16'd500;
            r_cfg.hover_dwell_ms    <= 16'd10000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SEPARATION_ALT: r_cfg.separation_alt_cm <= i_cfg_data[22:0];
                CFG_HOVER_ALT:      r_cfg.hover_alt_cm      <= i_cfg_data[22:0];
                CFG_SLOW_ALT:       r_cfg.slow_alt_cm       <= i_cfg_data[22:0];
                CFG_GROUND_ALT:     r_cfg.ground_alt_cm     <= $signed(i_cfg_data[23:0]);
                CFG_EMERG_ALT_MIN:  r_cfg.emerg_alt_min_cm  <= i_cfg_data[22:0];
                CFG_EMERG_SPEED:    r_cfg.emerg_speed_cms   <= i_cfg_data[14:0];
                CFG_EMERG_CONFIRM:  r_cfg.emerg_confirm_ms  <= i_cfg_data[15:0];
                CFG_HOVER_TIME:     r_cfg.hover_dwell_ms    <= i_cfg_data[15:0];
                default:            r_cfg                   <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/dms_core.sv -----
// Descent mission sequencer: phase state machine, overspeed timer and result
// forming for one item per cycle while i_fire is set. Depends on dms_pkg.
module dms_core #(
    parameter int TIME_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  dms_pkg::t_in_item  i_item,
    input  dms_pkg::t_cfg      i_cfg,
    output dms_pkg::t_out_item o_result
);
    import dms_pkg::*;

    // Mission state
    t_phase                 r_phase,     n_phase;
    logic                   r_active,    n_active;
    logic [TIME_BITS-1:0]   r_entry,     n_entry;
    logic                   r_os_timing, n_os_timing;
    logic [TIME_BITS-1:0]   r_os_start,  n_os_start;
    logic                   r_sep,       n_sep;
    logic                   r_para,      n_para;
    logic                   r_armed,     n_armed;

    logic [TIME_BITS-1:0]   w_now;
    logic [TIME_BITS-1:0]   w_phase_dt;
    logic signed [16:0]     w_speed_lim;
    logic signed [16:0]     w_vs;
    logic                   w_overspeed;
    logic [1:0]             w_mode;

    // Motors are armed in the powered phases only
    function automatic logic phase_arms(t_phase p);
        return (p == PH_POWERED) || (p == PH_HOVER) ||
               (p == PH_DESCENT) || (p == PH_LANDING);
    endfunction

    assign w_now       = TIME_BITS'(i_item.now_ms);
    assign w_speed_lim = -$signed({2'b00, i_cfg.emerg_speed_cms});
    assign w_vs        = $signed({i_item.vspeed_cms[15], i_item.vspeed_cms});
    assign w_overspeed = (i_item.altitude_cm > $signed({1'b0, i_cfg.emerg_alt_min_cm})) &&
                         (w_vs <= w_speed_lim);

    // Next state
    always_comb begin
        t_phase v_ph;
        logic   v_enter;
        logic   v_emerg;
        logic   v_sep;
        logic   v_para;

        v_ph        = r_phase;
        v_enter     = 1'b0;
        v_emerg     = 1'b0;
        v_sep       = r_sep;
        v_para      = r_para;
        n_active    = r_active;
        n_os_timing = r_os_timing;
        n_os_start  = r_os_start;

        if (i_item.cmd == CMD_START) begin
            n_active    = 1'b1;
            n_os_timing = 1'b0;
            n_os_start  = '0;
            v_ph        = PH_FALL;
            v_enter     = 1'b1;
            v_sep       = 1'b0;
            v_para      = 1'b0;
        end else if (i_item.cmd == CMD_STOP) begin
            n_active = 1'b0;
            v_ph     = PH_DONE;
            v_enter  = 1'b1;
            v_sep    = 1'b0;
            v_para   = 1'b0;
        end else if (i_item.cmd == CMD_UPDATE && r_active) begin
            if (!i_item.sensor_ok) begin
                // Bad sensor data: straight to parachute
                v_ph    = PH_EMERG;
                v_enter = 1'b1;
                v_sep   = 1'b0;
                v_para  = 1'b1;
            end else begin
                v_sep  = 1'b0;
                v_para = 1'b0;
                // Emergency check, timer runs only outside done/emergency
                if (r_phase != PH_EMERG && r_phase != PH_DONE) begin
                    if (i_item.emergency_request) begin
                        v_emerg = 1'b1;
                    end else if (w_overspeed) begin
                        if (!r_os_timing) begin
                            n_os_timing = 1'b1;
                            n_os_start  = w_now;
                        end else begin
                            v_emerg = ((w_now - r_os_start) >=
                                       TIME_BITS'(i_cfg.emerg_confirm_ms));
                        end
                    end else begin
                        n_os_timing = 1'b0;
                        n_os_start  = '0;
                    end
                end
                if (v_emerg) begin
                    v_ph    = PH_EMERG;
                    v_enter = 1'b1;
                end
                // Phase transitions
                unique case (v_ph)
                    PH_FALL: begin
                        if (i_item.altitude_cm <= $signed({1'b0, i_cfg.separation_alt_cm})) begin
                            v_ph    = PH_SEPARATE;
                            v_enter = 1'b1;
                        end
                    end
                    PH_SEPARATE: begin
                        v_sep = 1'b1;
                        if (i_item.sep_confirmed) begin
                            v_ph    = PH_POWERED;
                            v_enter = 1'b1;
                            v_sep   = 1'b0;
                        end
                    end
                    PH_POWERED: begin
                        if (i_item.altitude_cm <= $signed({1'b0, i_cfg.hover_alt_cm})) begin
                            v_ph    = PH_HOVER;
                            v_enter = 1'b1;
                        end
                    end
                    PH_HOVER: begin
                        if ((w_now - r_entry) >= TIME_BITS'(i_cfg.hover_dwell_ms)) begin
                            v_ph    = PH_DESCENT;
                            v_enter = 1'b1;
                        end
                    end
                    PH_DESCENT: begin
                        if (i_item.altitude_cm <= $signed({1'b0, i_cfg.slow_alt_cm})) begin
                            v_ph    = PH_LANDING;
                            v_enter = 1'b1;
                        end
                    end
                    PH_LANDING: begin
                        if (i_item.touchdown ||
                            i_item.altitude_cm <= i_cfg.ground_alt_cm) begin
                            v_ph    = PH_DONE;
                            v_enter = 1'b1;
                        end
                    end
                    PH_DONE: begin
                        v_sep = 1'b0;
                    end
                    PH_EMERG: begin
                        v_para = 1'b1;
                    end
                    default: begin
                        v_ph = r_phase;
                    end
                endcase
            end
        end

        // Entering a phase stamps the time and re-derives motor arm
        n_phase = v_ph;
        n_sep   = v_sep;
        n_para  = v_para;
        n_entry = v_enter ? w_now : r_entry;
        n_armed = v_enter ? phase_arms(v_ph) : r_armed;
    end

    // Time in phase wraps at the timer width before it is cut to 32 bits
    assign w_phase_dt = w_now - n_entry;

    // Outputs: control loop mode only when an update holds a flying phase
    always_comb begin
        w_mode = VM_NONE;
        if (i_item.cmd == CMD_UPDATE && r_active && i_item.sensor_ok &&
            n_phase == r_phase) begin
            unique case (r_phase) inside
                PH_POWERED, PH_DESCENT: w_mode = VM_ACTIVE;
                PH_HOVER:               w_mode = VM_HOVER;
                PH_LANDING:             w_mode = VM_SOFT;
                default:                w_mode = VM_NONE;
            endcase
        end
        o_result.phase          = n_phase;
        o_result.sep_fire       = n_sep;
        o_result.parachute_cmd  = n_para;
        o_result.motors_armed   = n_armed;
        o_result.velocity_mode  = w_mode;
        o_result.phase_time_ms  = 32'(w_phase_dt);
    end

    // State registers advance once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FALL;
            r_active    <= 1'b0;
            r_entry     <= '0;
            r_os_timing <= 1'b0;
            r_os_start  <= '0;
            r_sep       <= 1'b0;
            r_para      <= 1'b0;
            r_armed     <= 1'b0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_active    <= n_active;
            r_entry     <= n_entry;
            r_os_timing <= n_os_timing;
            r_os_start  <= n_os_start;
            r_sep       <= n_sep;
            r_para      <= n_para;
            r_armed     <= n_armed;
        end
    end

`ifndef SYNTHESIS
    // Motor arm always agrees with the phase held
    a_armed_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed == ((r_phase == PH_POWERED) || (r_phase == PH_HOVER) ||
                    (r_phase == PH_DESCENT) || (r_phase == PH_LANDING)))
        else $error("motor arm out of step with phase");

    // Parachute only fires in emergency
    a_para_emerg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_para |-> (r_phase == PH_EMERG))
        else $error("parachute command outside emergency");

    // Separation only commanded while separating
    a_sep_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sep |-> (r_phase == PH_SEPARATE))
        else $error("separation command outside separation phase");

    // Nothing in the mission state moves without an item
    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> ($stable(r_phase) && $stable(r_entry) && $stable(r_active)))
        else $error("mission state changed without an item");
`endif

endmodule

// ----- rtl/descent_mission_sequencer_top.sv -----
// Descent mission sequencer top level: input register, core, result register.
// Depends on dms_pkg, dms_cfg_regs and dms_core.
//
//  channel  direction  handshake                payload
//  in       sink       i_in_valid / o_in_stall  i_in  (t_in_item)
//  out      source     o_out_valid / i_out_stall o_out (t_out_item)
//  cfg      sink       i_cfg_we                 i_cfg_idx, i_cfg_data
//
// One item per clock sustained while the output is not stalled; an item passes
// from the input register to the result register, with the phase logic in between.
// Reset is synchronous, active low, and clears control state and valid flags.
// A stalled result stays in the result register; the input register still
// takes an item, and o_in_stall rises only when both stages hold items and
// the output is stalled.
module descent_mission_sequencer_top #(
    parameter int TIME_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  dms_pkg::t_in_item              i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output dms_pkg::t_out_item             o_out,
    input  logic                           i_cfg_we,
    input  logic [dms_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dms_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dms_pkg::*;

    logic      r_s1_valid;
    t_in_item  r_s1_item;
    logic      r_out_valid;
    t_out_item r_out;

    t_cfg      w_cfg;
    t_out_item w_result;
    logic      w_out_free;
    logic      w_s1_move;
    logic      w_in_take;

    // Handshake
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_s1_move  = r_s1_valid && w_out_free;
    assign o_in_stall = r_s1_valid && !w_out_free;
    assign w_in_take  = i_in_valid && !o_in_stall;

    dms_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    dms_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_s1_move),
        .i_item   (r_s1_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_take) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1_item <= i_in;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    // An item leaving the input register shows up as a result next cycle
    a_move_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_move |=> o_out_valid)
        else $error("item lost between input and result register");

    // A held result is not overwritten while stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !w_s1_move)
        else $error("result overwritten under stall");

    // Input side only stalls when both stages are occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid))
        else $error("input stalled with a free stage");
`endif

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for descent_mission_sequencer_top: randomized flights and noise
// items checked against an in-bench phase predictor. Depends on rtl/dms_pkg.sv and the RTL.
module tb;
    import dms_pkg::*;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         QUIET_LIMIT  = 2000;
    localparam int         HOLD_CYCLES  = 60;
    localparam int         DRAIN_CYCLES = 4;
    localparam t_cfg       RESET_CFG    = '{23'd100000, 23'd20000, 23'd5000, 24'sd0,
                                            23'd10000, 15'd2000, 16'd500, 16'd10000};

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in        = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    descent_mission_sequencer_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Predictor state, mirrors the block after reset
    t_cfg        cfg_m      = RESET_CFG;
    t_phase      cur_phase  = PH_FALL;
    logic        mission_on = 1'b0;
    logic [31:0] entry_ms   = '0;
    logic        os_timing  = 1'b0;
    logic [31:0] os_start   = '0;
    logic        sep_cmd    = 1'b0;
    logic        chute_cmd  = 1'b0;
    logic        arm_cmd    = 1'b0;

    // Bench bookkeeping
    t_in_item    pending[$];
    t_out_item   expected_status[$];
    t_out_item   status_want;
    int          items_queued  = 0;
    int          mismatches    = 0;
    int          quiet_cycles  = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_asked    = 0;
    int          hold_served   = 0;
    int          hold_left     = 0;

    function automatic void enter_phase(t_phase p, logic [31:0] t);
        cur_phase = p;
        entry_ms  = t;
        sep_cmd   = 1'b0;
        chute_cmd = 1'b0;
        arm_cmd   = (p >= PH_POWERED && p <= PH_LANDING);
    endfunction

    // Direct request wins; otherwise overspeed above the floor must persist
    function automatic logic overspeed_trip(t_in_item it);
        if (it.emergency_request)
            return 1'b1;
        if (int'(it.altitude_cm) > int'(cfg_m.emerg_alt_min_cm) &&
            int'(it.vspeed_cms) <= -int'(cfg_m.emerg_speed_cms)) begin
            if (!os_timing) begin
                os_timing = 1'b1;
                os_start  = it.now_ms;
                return 1'b0;
            end
            return (it.now_ms - os_start) >= 32'(cfg_m.emerg_confirm_ms);
        end
        os_timing = 1'b0;
        os_start  = '0;
        return 1'b0;
    endfunction

    // Advance the predicted sequencer by one item and return its status
    function automatic t_out_item mission_step(t_in_item it);
        t_out_item   r;
        logic [1:0]  vmode = VM_NONE;
        logic [31:0] t     = it.now_ms;
        int          alt   = int'(it.altitude_cm);
        if (it.cmd == CMD_START) begin
            mission_on = 1'b1;
            os_timing  = 1'b0;
            os_start   = '0;
            enter_phase(PH_FALL, t);
        end else if (it.cmd == CMD_STOP) begin
            mission_on = 1'b0;
            enter_phase(PH_DONE, t);
        end else if (it.cmd == CMD_UPDATE && mission_on) begin
            if (!it.sensor_ok) begin
                enter_phase(PH_EMERG, t);
                chute_cmd = 1'b1;
            end else begin
                sep_cmd   = 1'b0;
                chute_cmd = 1'b0;
                if (cur_phase != PH_EMERG && cur_phase != PH_DONE && overspeed_trip(it))
                    enter_phase(PH_EMERG, t);
                case (cur_phase)
                    PH_FALL: begin
                        if (alt <= int'(cfg_m.separation_alt_cm))
                            enter_phase(PH_SEPARATE, t);
                    end
                    PH_SEPARATE: begin
                        sep_cmd = 1'b1;
                        if (it.sep_confirmed)
                            enter_phase(PH_POWERED, t);
                    end
                    PH_POWERED: begin
                        if (alt <= int'(cfg_m.hover_alt_cm))
                            enter_phase(PH_HOVER, t);
                        else
                            vmode = VM_ACTIVE;
                    end
                    PH_HOVER: begin
                        if (t - entry_ms >= 32'(cfg_m.hover_dwell_ms))
                            enter_phase(PH_DESCENT, t);
                        else
                            vmode = VM_HOVER;
                    end
                    PH_DESCENT: begin
                        if (alt <= int'(cfg_m.slow_alt_cm))
                            enter_phase(PH_LANDING, t);
                        else
                            vmode = VM_ACTIVE;
                    end
                    PH_LANDING: begin
                        if (it.touchdown || alt <= int'(cfg_m.ground_alt_cm))
                            enter_phase(PH_DONE, t);
                        else
                            vmode = VM_SOFT;
                    end
                    PH_DONE: ;
                    default: chute_cmd = 1'b1;
                endcase
            end
        end
        r.phase          = cur_phase;
        r.sep_fire       = sep_cmd;
        r.parachute_cmd  = chute_cmd;
        r.motors_armed   = arm_cmd;
        r.velocity_mode  = vmode;
        r.phase_time_ms  = t - entry_ms;
        return r;
    endfunction

    // Driver: predict on acceptance, then offer the next pending item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                expected_status.push_back(mission_step(i_in));
            if (!i_in_valid || !o_in_stall) begin
                if (pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_in       <= pending.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted status, drive the result stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_status.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: status with no item pending: %p", $realtime, o_out);
                    mismatches++;
                end else begin
                    status_want = expected_status.pop_front();
                    if (o_out.phase !== status_want.phase ||
                        o_out.sep_fire !== status_want.sep_fire ||
                        o_out.parachute_cmd !== status_want.parachute_cmd ||
                        o_out.motors_armed !== status_want.motors_armed ||
                        o_out.velocity_mode !== status_want.velocity_mode ||
                        o_out.phase_time_ms !== status_want.phase_time_ms) begin
                        if (mismatches < 10)
                            $display("%0t: status mismatch\n  want %p\n  got  %p",
                                     $realtime, status_want, o_out);
                        mismatches++;
                    end
                end
            end
            // long hold-off on request so the pipeline backs up into the input
            if (hold_served != hold_asked) begin
                hold_left   = HOLD_CYCLES;
                hold_served = hold_asked;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // Watchdog on cycles with no traffic in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_item(logic [1:0] c, logic [31:0] t, logic v, int alt, int vs,
                              logic sep, logic land, logic req);
        t_in_item it;
        it.cmd               = c;
        it.now_ms            = t;
        it.sensor_ok         = v;
        it.altitude_cm       = 24'(alt);
        it.vspeed_cms        = 16'(vs);
        it.sep_confirmed     = sep;
        it.touchdown         = land;
        it.emergency_request = req;
        pending.push_back(it);
        items_queued++;
    endtask

    // One flight: start, then a descent from at or above separation to at or below ground
    task automatic fly_mission();
        logic [31:0] t     = $urandom();
        longint      alt0  = longint'(cfg_m.separation_alt_cm) + int'($urandom_range(0, 3000));
        longint      fin   = longint'(cfg_m.ground_alt_cm) - int'($urandom_range(0, 300));
        int          n     = $urandom_range(8, 40);
        int          tmax  = $urandom_range(1, int'(cfg_m.hover_dwell_ms) / 3 + 300);
        bit          fast  = ($urandom_range(0, 9) < 3);
        int          spd   = int'(cfg_m.emerg_speed_cms);
        int          k;
        int          vs;
        int          pick;
        longint      a;
        logic [1:0]  c;
        queue_item(CMD_START, t, 1'b1, int'($urandom()), int'($urandom()), 1'b0, 1'b0, 1'b0);
        for (k = 0; k < n; k++) begin
            t = t + (($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, tmax));
            a = alt0 - (alt0 - fin) * (k + 1) / n;
            // land exactly on a threshold now and then
            case ($urandom_range(0, 15))
                0: a = longint'(cfg_m.separation_alt_cm);
                1: a = longint'(cfg_m.hover_alt_cm);
                2: a = longint'(cfg_m.slow_alt_cm);
                3: a = longint'(cfg_m.ground_alt_cm);
                4: a = longint'(cfg_m.emerg_alt_min_cm) + int'($urandom_range(0, 1));
                default: ;
            endcase
            if (a > 8388607)
                a = 8388607;
            if (a < -8388608)
                a = -8388608;
            if ($urandom_range(0, 9) == 0)
                vs = int'($urandom_range(0, 65535)) - 32768;
            else if (fast)
                vs = -spd - int'($urandom_range(0, 200));
            else
                vs = -int'($urandom_range(0, (spd > 0) ? spd - 1 : 0));
            if (vs < -32768)
                vs = -32768;
            pick = $urandom_range(0, 199);
            if (pick < 3)
                c = CMD_STOP;
            else if (pick < 5)
                c = CMD_UNUSED;
            else if (pick < 7)
                c = CMD_START;
            else
                c = CMD_UPDATE;
            queue_item(c, t, $urandom_range(0, 59) != 0, int'(a), vs,
                       $urandom_range(0, 2) == 0, $urandom_range(0, 19) == 0,
                       $urandom_range(0, 99) == 0);
        end
    endtask

    // Mostly flights, with bursts of fully random items
    task automatic queue_random(int n);
        int goal = items_queued + n;
        while (items_queued < goal) begin
            if ($urandom_range(0, 99) < 85)
                fly_mission();
            else
                repeat ($urandom_range(1, 5))
                    queue_item(2'($urandom_range(0, 3)), $urandom(), 1'($urandom()),
                               int'($urandom()), int'($urandom()), 1'($urandom()),
                               1'($urandom()), 1'($urandom()));
        end
    endtask

    // Wait until every item is through, then let the pipeline settle
    task automatic drain();
        do
            @(negedge i_clk);
        while (pending.size() != 0 || i_in_valid || expected_status.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
    endtask

    task automatic write_setting(t_cfg c);
        write_reg(CFG_SEPARATION_ALT, 24'(c.separation_alt_cm));
        write_reg(CFG_HOVER_ALT,      24'(c.hover_alt_cm));
        write_reg(CFG_SLOW_ALT,       24'(c.slow_alt_cm));
        write_reg(CFG_GROUND_ALT,     24'(c.ground_alt_cm));
        write_reg(CFG_EMERG_ALT_MIN,  24'(c.emerg_alt_min_cm));
        write_reg(CFG_EMERG_SPEED,    24'(c.emerg_speed_cms));
        write_reg(CFG_EMERG_CONFIRM,  24'(c.emerg_confirm_ms));
        write_reg(CFG_HOVER_TIME,     24'(c.hover_dwell_ms));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_m = c;
    endtask

    // Stimulus sequence
    initial begin
        t_cfg setting;
        int   s;
        send_idle_pct = 32;
        recv_idle_pct = 49;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk through the sequence with reset settings
        queue_item(CMD_UPDATE, 32'd77, 1'b1, 8388607, 32767, 1'b1, 1'b1, 1'b1);
        queue_item(CMD_UNUSED, 32'hFFFF_FFFF, 1'b0, -8388608, -32768, 1'b1, 1'b1, 1'b1);
        queue_item(CMD_START, 32'd1000, 1'b1, 0, 0, 1'b0, 1'b0, 1'b0);
        queue_item(CMD_UPDATE, 32'd1100, 1'b1, 8388607, 32767, 1'b1, 1'b1, 1'b0);
        queue_item(CMD_UPDATE, 32'd1200, 1'b1, 100000, -100, 1'b0, 1'b0, 1'b0);
        queue_item(CMD_UPDATE, 32'd1300, 1'b1, 99000, -100, 1'b0, 1'b0, 1'b0);
        queue_item(CMD_UPDATE, 32'd1400, 1'b1, 98000, -100, 1'b1, 1'b0, 1'b0);
        queue_item(CMD_UPDATE, 32'd1500, 1'b1, 50000, -1999, 1'b0, 1'b0, 1'b0);
        // overspeed: timer starts, not yet confirmed, then confirmed
        queue_item(CMD_UPDATE, 32'd1600, 1'b1, 50000, -2000, 1'b0, 1'b0, 1'b0);
        queue_item(CMD_UPDATE, 32'd2099, 1'b1, 50000, -2500, 1'b0, 1'b0, 1'b0);
        queue_item(CMD_UPDATE, 32'd2100, 1'b1, 50000, -32768, 1'b0, 1'b0, 1'b0);
        queue_item(CMD_UPDATE, 32'd2200, 1'b1, 40000, -100, 1'b0, 1'b0, 1'b0);
        // second flight across the time wrap, at the overspeed floor
        queue_item(CMD_START, 32'hFFFF_FF00, 1'b1, 0, 0, 1'b0, 1'b0, 1'b0);
        queue_item(CMD_UPDATE, 32'hFFFF_FF10, 1'b1, 10000, -30000, 1'b0, 1'b0, 1'b0);
        queue_item(CMD_UPDATE, 32'hFFFF_FF20, 1'b1, 20000, -100, 1'b1, 1'b0, 1'b0);
        queue_item(CMD_UPDATE, 32'hFFFF_FF30, 1'b1, 20000, -100, 1'b0, 1'b0, 1'b0);
        queue_item(CMD_UPDATE, 32'h0000_2000, 1'b1, 19000, 0, 1'b0, 1'b0, 1'b0);
        queue_item(CMD_UPDATE, 32'h0000_2640, 1'b1, 19000, 0, 1'b0, 1'b0, 1'b0);
        queue_item(CMD_UPDATE, 32'h0000_2700, 1'b1, 5000, -100, 1'b0, 1'b0, 1'b0);
        queue_item(CMD_UPDATE, 32'h0000_2800, 1'b1, 1, -50, 1'b0, 1'b0, 1'b0);
        queue_item(CMD_UPDATE, 32'h0000_2900, 1'b1, -8388608, 0, 1'b0, 1'b0, 1'b0);
        // done ignores request and overspeed
        queue_item(CMD_UPDATE, 32'h0000_2A00, 1'b1, 50000, -32768, 1'b0, 1'b0, 1'b1);
        // direct request, invalid data, stop, then an update while inactive
        queue_item(CMD_START, 32'h0000_3000, 1'b1, 0, 0, 1'b0, 1'b0, 1'b0);
        queue_item(CMD_UPDATE, 32'h0000_3001, 1'b1, 200000, -100, 1'b0, 1'b0, 1'b1);
        queue_item(CMD_START, 32'h0000_4000, 1'b1, 0, 0, 1'b0, 1'b0, 1'b0);
        queue_item(CMD_UPDATE, 32'h0000_4001, 1'b0, 200000, -100, 1'b0, 1'b0, 1'b0);
        queue_item(CMD_STOP, 32'h0000_5000, 1'b1, 0, 0, 1'b0, 1'b0, 1'b0);
        queue_item(CMD_UPDATE, 32'h0000_5100, 1'b0, 0, 0, 1'b1, 1'b1, 1'b1);
        queue_random(160);

        for (s = 1; s <= 6; s++) begin
            drain();
            if (s == 2) begin
                send_idle_pct = 49;
                recv_idle_pct = 32;
            end else if (s == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (s)
                1: setting = '{23'd3000, 23'd1500, 23'd600, 24'sd50,
                               23'd200, 15'd300, 16'd200, 16'd0};
                2: setting = '{23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 24'sh7FFFFF,
                               23'd0, 15'd0, 16'd0, 16'd0};
                3: setting = '{23'd0, 23'd0, 23'd0, 24'sh800000,
                               23'h7FFFFF, 15'h7FFF, 16'hFFFF, 16'hFFFF};
                4, 5: begin
                    setting.separation_alt_cm = 23'($urandom_range(2000, 300000));
                    setting.hover_alt_cm      =
                        23'($urandom_range(0, setting.separation_alt_cm));
                    setting.slow_alt_cm       = 23'($urandom_range(0, setting.hover_alt_cm));
                    setting.ground_alt_cm     = 24'(int'($urandom_range(0, 1000)) - 500);
                    setting.emerg_alt_min_cm  =
                        23'($urandom_range(0, setting.separation_alt_cm));
                    setting.emerg_speed_cms   = 15'($urandom_range(0, 4000));
                    setting.emerg_confirm_ms  = 16'($urandom_range(0, 3000));
                    setting.hover_dwell_ms    = 16'($urandom_range(0, 20000));
                end
                default: setting = RESET_CFG;
            endcase
            write_setting(setting);
            queue_random(185);
            // back up the pipeline while items keep coming
            if (s == 1 || s == 5)
                hold_asked++;
        end

        drain();
        if (mismatches == 0 && expected_status.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/dms_pkg.sv
rtl/dms_cfg_regs.sv
rtl/dms_core.sv
rtl/descent_mission_sequencer_top.sv
verif/tb.sv
